FILE: hw/rtl/stid_pkg.sv
// Shared constants and types for the sorted table insert/delete unit.
package stid_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

FILE: hw/rtl/stid_ctrl.sv
// Controller state machine for the sorted table insert/delete unit.
module stid_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  stid_pkg::dp_status_t  status,
    output stid_pkg::ctrl_cmd_t   cmd
);

    stid_pkg::state_t state_reg;
    stid_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stid_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            stid_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stid_pkg::ST_COMPARE;
                end
            end
            stid_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = stid_pkg::ST_UPDATE;
            end
            stid_pkg::ST_UPDATE:
            begin
                // hold the table until the previous result has left
                if (!out_valid_reg || out_ready)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = stid_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stid_pkg::ST_IDLE;
            end
        endcase
        // status is informational; a full or empty table takes the same path through the states
        if (status.full && status.empty)
        begin
            state_next = stid_pkg::ST_IDLE;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/stid_datapath.sv
// Row of compare-and-shift cells holding the sorted entries and the count.
module stid_datapath
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  stid_pkg::ctrl_cmd_t                   cmd,
    input  logic                                  operation,
    input  logic signed [stid_pkg::VALUE_W-1:0]   value,
    output stid_pkg::dp_status_t                  status,
    output logic                                  ok,
    output logic [stid_pkg::COUNT_OUT_W-1:0]      count_after
);

    localparam int CAP = stid_pkg::CAPACITY;

    logic                                op_reg;
    logic signed [stid_pkg::VALUE_W-1:0] value_reg;
    logic signed [stid_pkg::VALUE_W-1:0] entry_reg [CAP];
    logic signed [stid_pkg::VALUE_W-1:0] entry_next [CAP];
    logic [stid_pkg::CNT_W-1:0]          count_reg;
    logic [stid_pkg::CNT_W-1:0]          count_next;
    logic [CAP-1:0]                      ge_reg;
    logic [CAP-1:0]                      ge_next;
    logic                                found_reg;
    logic                                found_next;
    logic                                ok_reg;
    logic                                ok_next;
    logic [CAP-1:0]                      hit;
    logic [CAP-1:0]                      boundary;
    logic                                full;

    assign full         = (count_reg == stid_pkg::CNT_W'(CAP));
    assign status.full  = full;
    assign status.empty = (count_reg == '0);

    // Each cell: is this slot at or beyond the insertion point?
    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            ge_next[i] = !((stid_pkg::CNT_W'(i) < count_reg) && (value_reg > entry_reg[i]));
            hit[i]     = ge_next[i] && ((i == 0) || !ge_next[(i == 0) ? 0 : i - 1])
                         && (stid_pkg::CNT_W'(i) < count_reg) && (entry_reg[i] == value_reg);
        end
        found_next = |hit;
    end

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            boundary[i] = ge_reg[i] && ((i == 0) || !ge_reg[(i == 0) ? 0 : i - 1]);
        end
    end

    // Shift the cells up on insert or down on delete.
    always_comb
    begin
        count_next = count_reg;
        ok_next    = 1'b0;
        for (int i = 0; i < CAP; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (op_reg == stid_pkg::OP_INSERT)
        begin
            if (!full)
            begin
                ok_next    = 1'b1;
                count_next = count_reg + stid_pkg::CNT_W'(1);
                for (int i = 0; i < CAP; i++)
                begin
                    if (boundary[i])
                    begin
                        entry_next[i] = value_reg;
                    end
                    else if (ge_reg[i] && (i > 0))
                    begin
                        entry_next[i] = entry_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
        else
        begin
            if (found_reg)
            begin
                ok_next    = 1'b1;
                count_next = count_reg - stid_pkg::CNT_W'(1);
                for (int i = 0; i < CAP - 1; i++)
                begin
                    if (ge_reg[i])
                    begin
                        entry_next[i] = entry_reg[i + 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
        if (cmd.compare)
        begin
            ge_reg    <= ge_next;
            found_reg <= found_next;
        end
        if (cmd.update)
        begin
            ok_reg <= ok_next;
            for (int i = 0; i < CAP; i++)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    assign ok          = ok_reg;
    assign count_after = stid_pkg::COUNT_OUT_W'(count_reg);

endmodule

FILE: hw/rtl/sorted_table_insert_delete_unit.sv
// Top level of the sorted table insert/delete unit.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  input    | in_valid / in_ready  | operation, value
//  output   | out_valid / out_ready| ok, count_after
//
// Each transaction runs through accept, a parallel compare across all cells,
// then one shift/update of the cell row. The next transaction can be
// accepted while a result still waits in the output register; its update
// step holds until that result is taken. Reset empties the table (the count
// clears; entry contents are not cleared). No clearing pass is needed.
module sorted_table_insert_delete_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic signed [stid_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ok,
    output logic [stid_pkg::COUNT_OUT_W-1:0]     count_after
);

    stid_pkg::ctrl_cmd_t  cmd;
    stid_pkg::dp_status_t status;

    // sequence accept, compare and update
    stid_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // hold the sorted cells, the count and the result
    stid_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .value       (value),
        .status      (status),
        .ok          (ok),
        .count_after (count_after)
    );

    // busy right after accepting a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a transaction while busy");

    // a result appears only when a transaction was in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without a transaction in flight");

    // a failed operation leaves the count unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid) && !ok) |-> (count_after == $past(count_after)))
        else $error("failed operation changed the count");

endmodule
